// ----- rtl/sarf_pkg.sv -----
`timescale 1ns / 1ps
package sarf_pkg;

	localparam int AXES      = 6;
	localparam int SAMPLE_W  = 32;
	localparam int COEF_W    = 16;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	localparam int COEF_COUNT = 8;
	localparam int COEF_IW   = 3;
	localparam int AXIS_W    = 3;
	localparam int FRAC_SHIFT = 15;
	localparam int ROW_W     = AXES * SAMPLE_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam coef_t COEF0_RESET = 16'sd32767;

endpackage

// ----- rtl/six_axis_ring_fir_filter.sv -----
`timescale 1ns / 1ps
// channel   direction  signals                          contents
// s_axis    in         tvalid tready tdata[191:0] tuser  push or read request
// m_axis    out        tvalid tready tdata[191:0]        six filtered axes
// cfg       in         we index[2:0] data[15:0]          tap weights coef_0..coef_7
//
// a push writes one history row and advances the ring pointer
// a read runs one shared 32x16 multiplier over every tap and axis
// after reset the history reads as zero through one valid bit per row
// s_tready is low while a read is in progress, or while a finished read waits for an earlier result to leave m_axis
module six_axis_ring_fir_filter #(
	parameter int TAPS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
	input  logic         s_tuser,  // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,  // filt_accel_x, filt_accel_y, filt_accel_z,
	                               // filt_rate_x, filt_rate_y, filt_rate_z
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int ACC_W = sarf_pkg::PROD_W + PTR_W;
	localparam logic [PTR_W-1:0] LAST_TAP = PTR_W'(TAPS - 1);
	localparam logic [sarf_pkg::AXIS_W-1:0] LAST_AXIS = sarf_pkg::AXIS_W'(sarf_pkg::AXES - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] ptr_next;
	logic [TAPS-1:0] row_valid_q;
	logic [PTR_W-1:0] slot_q;
	logic [PTR_W-1:0] tap_q;
	logic [sarf_pkg::AXIS_W-1:0] axis_q;
	sarf_pkg::coef_t coef_q [sarf_pkg::COEF_COUNT];

	logic in_acc;
	logic push_acc;
	logic read_acc;
	logic ram_re;
	logic [PTR_W-1:0] ram_raddr;
	logic [sarf_pkg::ROW_W-1:0] row_rdata;
	logic rd_valid_s1;

	sarf_pkg::sample_t samp;
	sarf_pkg::coef_t coef_cur;
	logic [sarf_pkg::COEF_IW-1:0] coef_idx;
	sarf_pkg::prod_t prod_s1;
	logic [sarf_pkg::AXIS_W-1:0] prod_axis_s1;
	logic prod_vld_s1;

	logic signed [ACC_W-1:0] acc_q [sarf_pkg::AXES];
	logic [sarf_pkg::ROW_W-1:0] res_row;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign push_acc = in_acc && (s_tuser == sarf_pkg::OP_PUSH);
	assign read_acc = in_acc && (s_tuser == sarf_pkg::OP_READ);
	assign ptr_next = (ptr_q == LAST_TAP) ? '0 : ptr_q + 1'b1;
	assign out_free = !m_tvalid || m_tready;

	// next tap row is fetched on the last axis of the current tap
	assign ram_re    = (state_q == ST_RD) || ((state_q == ST_MUL) && (axis_q == LAST_AXIS));
	assign ram_raddr = slot_q;

	sarf_ram #(
		.WIDTH(sarf_pkg::ROW_W),
		.DEPTH(TAPS)
	) u_hist (
		.clk  (clk),
		.we   (push_acc),
		.waddr(ptr_next),
		.wdata(s_tdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(row_rdata)
	);

	always_comb begin
		coef_idx = sarf_pkg::COEF_IW'(tap_q);
		coef_cur = coef_q[coef_idx];
		samp     = '0;
		if (rd_valid_s1) begin
			samp = row_rdata[axis_q*sarf_pkg::SAMPLE_W +: sarf_pkg::SAMPLE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= sarf_pkg::COEF0_RESET;
			for (int i = 1; i < sarf_pkg::COEF_COUNT; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			row_valid_q <= '0;
			slot_q      <= '0;
			tap_q       <= '0;
			axis_q      <= '0;
			rd_valid_s1 <= 1'b0;
			prod_vld_s1 <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			prod_vld_s1 <= (state_q == ST_MUL);
			if (ram_re) begin
				rd_valid_s1 <= row_valid_q[ram_raddr];
				slot_q      <= (slot_q == '0) ? LAST_TAP : slot_q - 1'b1;
			end
			if ((state_q == ST_FIN) && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (push_acc) begin
						ptr_q                 <= ptr_next;
						row_valid_q[ptr_next] <= 1'b1;
					end
					if (read_acc) begin
						slot_q  <= ptr_q;
						tap_q   <= '0;
						axis_q  <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (axis_q == LAST_AXIS) begin
						axis_q <= '0;
						if (tap_q == LAST_TAP) begin
							state_q <= ST_DRAIN;
						end else begin
							tap_q <= tap_q + 1'b1;
						end
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1      <= samp * coef_cur;
		prod_axis_s1 <= axis_q;
		if (read_acc) begin
			for (int i = 0; i < sarf_pkg::AXES; i++) begin
				acc_q[i] <= '0;
			end
		end else if (prod_vld_s1) begin
			acc_q[prod_axis_s1] <= acc_q[prod_axis_s1] + ACC_W'(prod_s1);
		end
		if ((state_q == ST_FIN) && out_free) begin
			m_tdata <= res_row;
		end
	end

	// floor shift back to Q16.16 and saturate
	for (genvar g = 0; g < sarf_pkg::AXES; g++) begin : g_sat
		logic signed [ACC_W-1:0] shifted;
		logic [ACC_W-sarf_pkg::SAMPLE_W:0] hi;
		always_comb begin
			shifted = acc_q[g] >>> sarf_pkg::FRAC_SHIFT;
			hi      = shifted[ACC_W-1:sarf_pkg::SAMPLE_W-1];
			if ((&hi) || !(|hi)) begin
				res_row[g*sarf_pkg::SAMPLE_W +: sarf_pkg::SAMPLE_W] =
					shifted[sarf_pkg::SAMPLE_W-1:0];
			end else if (hi[ACC_W-sarf_pkg::SAMPLE_W]) begin
				res_row[g*sarf_pkg::SAMPLE_W +: sarf_pkg::SAMPLE_W] = 32'h8000_0000;
			end else begin
				res_row[g*sarf_pkg::SAMPLE_W +: sarf_pkg::SAMPLE_W] = 32'h7fff_ffff;
			end
		end
	end

endmodule

// ----- rtl/sarf_ram.sv -----
`timescale 1ns / 1ps
module sarf_ram #(
	parameter int WIDTH = 192,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
